// ===== hdl/erp_pkg.sv =====
package erp_pkg;

  localparam int VTX_W      = 16;
  localparam int EPOCH_W    = 5;
  localparam int MAX_EPOCHS = 32;
  localparam int EPN_W      = 6;
  localparam int CNT_W      = 32;
  localparam int HIST_AW    = VTX_W + EPOCH_W;
  localparam int HIST_DEPTH = 1 << HIST_AW;
  localparam int LS_DEPTH   = 1 << VTX_W;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W     = 1;
  localparam int QCNT_W     = 2;

  localparam logic [CNT_W-1:0] EPOCH_LENGTH_RST  = CNT_W'(4096);
  localparam logic [EPN_W-1:0] EPOCHS_IN_USE_RST = EPN_W'(20);
  localparam logic             KIND_QUERY        = 1'b1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EPOCH_LENGTH,
    CFG_EPOCHS_IN_USE
  } cfg_idx_t;

  typedef enum logic {
    OP_ACCESS,
    OP_QUERY
  } op_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ACC,
    ST_MOD,
    ST_RD,
    ST_CALC,
    ST_WR,
    ST_QRD,
    ST_QCMP,
    ST_QOUT
  } state_t;

  typedef struct packed {
    logic             kind;
    logic [VTX_W-1:0] vertex;
  } in_item_t;

  typedef struct packed {
    logic [EPOCH_W-1:0] epoch;
    logic [CNT_W-1:0]   access_total;
    logic [CNT_W-1:0]   reuse_total;
  } out_item_t;

  typedef struct packed {
    op_t              op;
    logic [VTX_W-1:0] vertex;
  } cmd_t;

  typedef struct packed {
    logic [CNT_W-1:0] hit;
    logic [CNT_W-1:0] reuse;
  } hist_entry_t;

  typedef struct packed {
    logic             seen;
    logic [CNT_W-1:0] stamp;
  } ls_entry_t;

  function automatic logic [EPN_W-1:0] epochs_eff(input logic [EPN_W-1:0] e);
    logic [EPN_W-1:0] r;
    if (e == '0) begin
      r = EPN_W'(1);
    end else if (e > EPN_W'(MAX_EPOCHS)) begin
      r = EPN_W'(MAX_EPOCHS);
    end else begin
      r = e;
    end
    return r;
  endfunction

endpackage

// ===== hdl/epoch_access_reuse_profiler_top.sv =====
// Channel  Direction  Handshake            Payload
// in_      input      in_valid, in_stall   erp_pkg::in_item_t  {kind, vertex}
// out_     output     out_valid, out_stall erp_pkg::out_item_t {epoch, access_total, reuse_total}
// cfg_     input      cfg_valid, cfg_ready cfg_index, cfg_data
//
// An access passes the states ACC, RD, CALC and WR, WR waiting while a stalled result holds
// the output register; an epoch advance adds MOD, which subtracts the epochs in use until
// the index fits. The histogram memory has a single read port, so a query reads one entry
// per epoch in use in QRD, then passes QCMP and QOUT. One item is worked on at a time.
// After reset a clearing pass writes every entry of both memories before any item starts.
// A two-entry queue takes transactions while the back end works or the result is stalled.
module epoch_access_reuse_profiler_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  erp_pkg::in_item_t                 in_data,
  output logic                              in_stall,
  output logic                              out_valid,
  input  logic                              out_stall,
  output erp_pkg::out_item_t                out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [erp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [erp_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic [erp_pkg::CNT_W-1:0] epoch_length_r, epoch_length_nxt;
  logic [erp_pkg::EPN_W-1:0] epochs_in_use_r, epochs_in_use_nxt;
  logic                      cmd_valid;
  logic                      cmd_pop;
  erp_pkg::cmd_t             cmd;
  erp_pkg::cfg_idx_t         cfg_sel;

  assign cfg_ready = 1'b1;
  assign cfg_sel   = erp_pkg::cfg_idx_t'(cfg_index);

  always_comb begin
    epoch_length_nxt  = epoch_length_r;
    epochs_in_use_nxt = epochs_in_use_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_sel)
        erp_pkg::CFG_EPOCH_LENGTH: begin
          epoch_length_nxt = cfg_data[erp_pkg::CNT_W-1:0];
        end
        erp_pkg::CFG_EPOCHS_IN_USE: begin
          epochs_in_use_nxt = cfg_data[erp_pkg::EPN_W-1:0];
        end
        default: begin
          epoch_length_nxt = epoch_length_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      epoch_length_r  <= erp_pkg::EPOCH_LENGTH_RST;
      epochs_in_use_r <= erp_pkg::EPOCHS_IN_USE_RST;
    end else begin
      epoch_length_r  <= epoch_length_nxt;
      epochs_in_use_r <= epochs_in_use_nxt;
    end
  end

  erp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  erp_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop),
    .epoch_length  (epoch_length_r),
    .epochs_in_use (epochs_in_use_r),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data)
  );

endmodule

// ===== hdl/erp_front.sv =====
module erp_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  erp_pkg::in_item_t  in_data,
  output logic               in_stall,
  output logic               cmd_valid,
  output erp_pkg::cmd_t      cmd,
  input  logic               cmd_pop
);

  erp_pkg::cmd_t                q_r [erp_pkg::QUEUE_DEPTH];
  logic [erp_pkg::QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [erp_pkg::QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [erp_pkg::QCNT_W-1:0]   count_r, count_nxt;
  erp_pkg::cmd_t                push_cmd;
  logic                         push;
  logic                         pop;

  assign in_stall  = (count_r == erp_pkg::QCNT_W'(erp_pkg::QUEUE_DEPTH));
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (count_r != '0);
  assign pop       = cmd_pop && cmd_valid;
  assign cmd       = q_r[rd_ptr_r];

  always_comb begin
    push_cmd.op     = (in_data.kind == erp_pkg::KIND_QUERY) ? erp_pkg::OP_QUERY
                                                            : erp_pkg::OP_ACCESS;
    push_cmd.vertex = in_data.vertex;
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== hdl/erp_back.sv =====
module erp_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cmd_valid,
  input  erp_pkg::cmd_t                 cmd,
  output logic                          cmd_pop,
  input  logic [erp_pkg::CNT_W-1:0]     epoch_length,
  input  logic [erp_pkg::EPN_W-1:0]     epochs_in_use,
  output logic                          out_valid,
  input  logic                          out_stall,
  output erp_pkg::out_item_t            out_data
);

  erp_pkg::hist_entry_t hist_mem [erp_pkg::HIST_DEPTH];
  erp_pkg::ls_entry_t   ls_mem   [erp_pkg::LS_DEPTH];

  erp_pkg::state_t                 state_r, state_nxt;
  erp_pkg::cmd_t                   cur_r, cur_nxt;
  logic [erp_pkg::EPOCH_W-1:0]     epoch_index_r, epoch_index_nxt;
  logic [erp_pkg::CNT_W-1:0]       epoch_count_r, epoch_count_nxt;
  logic [erp_pkg::CNT_W-1:0]       global_count_r, global_count_nxt;
  logic [erp_pkg::EPN_W-1:0]       epoch_mod_r, epoch_mod_nxt;
  logic [erp_pkg::EPOCH_W-1:0]     scan_r, scan_nxt;
  logic                            pend_r, pend_nxt;
  logic [erp_pkg::EPOCH_W-1:0]     pend_h_r, pend_h_nxt;
  logic [erp_pkg::CNT_W-1:0]       best_r, best_nxt;
  logic [erp_pkg::EPOCH_W-1:0]     best_e_r, best_e_nxt;
  logic [erp_pkg::CNT_W-1:0]       hit_new_r, hit_new_nxt;
  logic [erp_pkg::CNT_W-1:0]       delta_r, delta_nxt;
  logic [erp_pkg::HIST_AW-1:0]     clr_r, clr_nxt;
  logic                            out_valid_r, out_valid_nxt;
  erp_pkg::out_item_t              out_data_r, out_data_nxt;

  erp_pkg::hist_entry_t            hist_rd_r;
  erp_pkg::ls_entry_t              ls_rd_r;
  logic                            hist_we, hist_re, ls_we, ls_re;
  logic [erp_pkg::HIST_AW-1:0]     hist_wa, hist_ra;
  erp_pkg::hist_entry_t            hist_wd;
  logic [erp_pkg::VTX_W-1:0]       ls_wa, ls_ra;
  erp_pkg::ls_entry_t              ls_wd;
  logic [erp_pkg::EPN_W-1:0]       n_eff;
  logic [erp_pkg::CNT_W-1:0]       reuse_sum;
  logic                            slot_free;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign n_eff     = erp_pkg::epochs_eff(epochs_in_use);
  assign reuse_sum = hist_rd_r.reuse + delta_r;
  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt        = state_r;
    cur_nxt          = cur_r;
    epoch_index_nxt  = epoch_index_r;
    epoch_count_nxt  = epoch_count_r;
    global_count_nxt = global_count_r;
    epoch_mod_nxt    = epoch_mod_r;
    scan_nxt         = scan_r;
    pend_nxt         = 1'b0;
    pend_h_nxt       = pend_h_r;
    best_nxt         = best_r;
    best_e_nxt       = best_e_r;
    hit_new_nxt      = hit_new_r;
    delta_nxt        = delta_r;
    clr_nxt          = clr_r;
    out_valid_nxt    = out_valid_r && out_stall;
    out_data_nxt     = out_data_r;
    cmd_pop          = 1'b0;
    hist_we          = 1'b0;
    hist_re          = 1'b0;
    ls_we            = 1'b0;
    ls_re            = 1'b0;
    hist_wa          = {cur_r.vertex, epoch_index_r};
    hist_ra          = {cur_r.vertex, epoch_index_r};
    hist_wd          = '0;
    ls_wa            = cur_r.vertex;
    ls_ra            = cur_r.vertex;
    ls_wd            = '0;

    if (pend_r && (hist_rd_r.reuse > best_r)) begin
      best_nxt   = hist_rd_r.reuse;
      best_e_nxt = pend_h_r;
    end

    case (state_r)
      erp_pkg::ST_CLEAR: begin
        hist_we = 1'b1;
        hist_wa = clr_r;
        ls_we   = 1'b1;
        ls_wa   = clr_r[erp_pkg::VTX_W-1:0];
        clr_nxt = clr_r + 1'b1;
        if (&clr_r) begin
          state_nxt = erp_pkg::ST_IDLE;
        end
      end
      erp_pkg::ST_IDLE: begin
        if (cmd_valid) begin
          cmd_pop    = 1'b1;
          cur_nxt    = cmd;
          best_nxt   = '0;
          best_e_nxt = '0;
          scan_nxt   = '0;
          state_nxt  = (cmd.op == erp_pkg::OP_QUERY) ? erp_pkg::ST_QRD : erp_pkg::ST_ACC;
        end
      end
      erp_pkg::ST_ACC: begin
        if (epoch_count_r > epoch_length) begin
          epoch_count_nxt = '0;
          epoch_mod_nxt   = {1'b0, epoch_index_r} + erp_pkg::EPN_W'(1);
          state_nxt       = erp_pkg::ST_MOD;
        end else begin
          state_nxt = erp_pkg::ST_RD;
        end
      end
      erp_pkg::ST_MOD: begin
        if (epoch_mod_r >= n_eff) begin
          epoch_mod_nxt = epoch_mod_r - n_eff;
        end else begin
          epoch_index_nxt = epoch_mod_r[erp_pkg::EPOCH_W-1:0];
          state_nxt       = erp_pkg::ST_RD;
        end
      end
      erp_pkg::ST_RD: begin
        hist_re          = 1'b1;
        ls_re            = 1'b1;
        epoch_count_nxt  = epoch_count_r + 1'b1;
        global_count_nxt = global_count_r + 1'b1;
        state_nxt        = erp_pkg::ST_CALC;
      end
      erp_pkg::ST_CALC: begin
        hit_new_nxt = hist_rd_r.hit + 1'b1;
        delta_nxt   = ls_rd_r.seen ? global_count_r - ls_rd_r.stamp : '0;
        state_nxt   = erp_pkg::ST_WR;
      end
      erp_pkg::ST_WR: begin
        if (slot_free) begin
          hist_we                   = 1'b1;
          hist_wd.hit               = hit_new_r;
          hist_wd.reuse             = reuse_sum;
          ls_we                     = 1'b1;
          ls_wd.seen                = 1'b1;
          ls_wd.stamp               = global_count_r;
          out_valid_nxt             = 1'b1;
          out_data_nxt.epoch        = epoch_index_r;
          out_data_nxt.access_total = hit_new_r;
          out_data_nxt.reuse_total  = reuse_sum;
          state_nxt                 = erp_pkg::ST_IDLE;
        end
      end
      erp_pkg::ST_QRD: begin
        hist_re    = 1'b1;
        hist_ra    = {cur_r.vertex, scan_r};
        pend_nxt   = 1'b1;
        pend_h_nxt = scan_r;
        if (({1'b0, scan_r} + erp_pkg::EPN_W'(1)) == n_eff) begin
          state_nxt = erp_pkg::ST_QCMP;
        end else begin
          scan_nxt = scan_r + 1'b1;
        end
      end
      erp_pkg::ST_QCMP: begin
        state_nxt = erp_pkg::ST_QOUT;
      end
      erp_pkg::ST_QOUT: begin
        if (slot_free) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.epoch        = best_e_r;
          out_data_nxt.access_total = '0;
          out_data_nxt.reuse_total  = best_r;
          state_nxt                 = erp_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = erp_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= erp_pkg::ST_CLEAR;
      epoch_index_r  <= '0;
      epoch_count_r  <= '0;
      global_count_r <= '0;
      pend_r         <= 1'b0;
      clr_r          <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      epoch_index_r  <= epoch_index_nxt;
      epoch_count_r  <= epoch_count_nxt;
      global_count_r <= global_count_nxt;
      pend_r         <= pend_nxt;
      clr_r          <= clr_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r       <= cur_nxt;
    epoch_mod_r <= epoch_mod_nxt;
    scan_r      <= scan_nxt;
    pend_h_r    <= pend_h_nxt;
    best_r      <= best_nxt;
    best_e_r    <= best_e_nxt;
    hit_new_r   <= hit_new_nxt;
    delta_r     <= delta_nxt;
    out_data_r  <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (hist_we) begin
      hist_mem[hist_wa] <= hist_wd;
    end
    if (hist_re) begin
      hist_rd_r <= hist_mem[hist_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (ls_we) begin
      ls_mem[ls_wa] <= ls_wd;
    end
    if (ls_re) begin
      ls_rd_r <= ls_mem[ls_ra];
    end
  end

endmodule

// ===== hdl/erp_checker.sv =====
module erp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input erp_pkg::out_item_t out_data
);

  logic [2:0] pend_r, pend_nxt;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  always_comb begin
    pend_nxt = pend_r;
    if (in_acc && !out_acc) begin
      pend_nxt = pend_r + 1'b1;
    end else if (out_acc && !in_acc) begin
      pend_nxt = pend_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_nxt;
    end
  end

  a_no_unrequested_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 3'd0)
    else $error("A result appeared with no transaction outstanding.");

  a_outstanding_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |-> pend_r <= 3'd4)
    else $error("More transactions are outstanding than the block can hold.");

  a_stalled_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("A stalled result changed or was dropped.");

  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("Reset did not empty the queue and the result register.");

endmodule

bind epoch_access_reuse_profiler_top erp_checker u_erp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
